@@ hw/rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
package bba_pkg;

  localparam int HEAP_LOG2      = 20;
  localparam int MIN_BLOCK_LOG2 = 10;
  localparam int DEPTH_MAX      = HEAP_LOG2 - MIN_BLOCK_LOG2;
  localparam int NODE_COUNT     = (1 << (DEPTH_MAX + 1)) - 1;
  localparam int NODE_W         = DEPTH_MAX + 1;
  localparam int DEP_W          = $clog2(DEPTH_MAX + 1);
  localparam int SIZE_W         = 21;
  localparam int LOG_W          = 5;

  // flag bit positions inside one node entry
  localparam int FLAG_SPLIT = 0;
  localparam int FLAG_FULL  = 1;

  typedef logic [1:0] flags_t;
  localparam flags_t FLAGS_CLEAR = 2'b00;
  localparam flags_t FLAGS_SPLIT = 2'b01;
  localparam flags_t FLAGS_FULL  = 2'b10;
  localparam flags_t FLAGS_BOTH  = 2'b11;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_BLOCK  = 2'd2
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // round a byte count up to a power of two, at least the minimum block
  function automatic logic [LOG_W-1:0] round_log2(input logic [SIZE_W-1:0] size);
    logic [LOG_W-1:0] k;
    k = LOG_W'(MIN_BLOCK_LOG2);
    for (int i = MIN_BLOCK_LOG2; i < SIZE_W; i++) begin
      if (((SIZE_W+1)'(1) << i) < {1'b0, size}) k = LOG_W'(i + 1);
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/buddy_block_allocator_core.sv @@
`timescale 1ns / 1ps
// a request walks the tree: node reads, splits on the way down, backtrack steps,
// ancestor checks on allocate and merge levels on free
// one request at a time; the next is taken only after the result has been accepted
// reset: synchronous; then a clearing pass zeroes the flags of every node, during
// which no request is taken (heap_base writes are)
module buddy_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [20:0] request_size,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] granted_address,
  output logic [4:0]  granted_size_log2
);

  localparam int NW = bba_pkg::NODE_W;
  localparam int DW = bba_pkg::DEP_W;
  localparam int LW = bba_pkg::LOG_W;

  typedef enum logic [20:0] {
    ST_CLR    = 21'h000001,
    ST_IDLE   = 21'h000002,
    ST_KCALC  = 21'h000004,
    ST_PREP   = 21'h000008,
    ST_S_RD   = 21'h000010,
    ST_S_EV   = 21'h000020,
    ST_S_BACK = 21'h000040,
    ST_S_WSPL = 21'h000080,
    ST_S_WL   = 21'h000100,
    ST_S_WR   = 21'h000200,
    ST_FOUND  = 21'h000400,
    ST_A_RD   = 21'h000800,
    ST_A_EV   = 21'h001000,
    ST_ADDR   = 21'h002000,
    ST_F_RD   = 21'h004000,
    ST_F_EV   = 21'h008000,
    ST_P_RD   = 21'h010000,
    ST_P_EV   = 21'h020000,
    ST_C_RD   = 21'h040000,
    ST_C_EV   = 21'h080000,
    ST_FIN    = 21'h100000
  } state_t;

  state_t state, state_next;

  logic [31:0]           heap_base;
  logic                  mode_r;
  logic [20:0]           size_r;
  logic [31:0]           addr_r;
  logic [LW-1:0]         k, k_next;
  logic [NW-1:0]         node, node_next;
  logic [NW-1:0]         fnode, fnode_next;
  logic [DW-1:0]         dep, dep_next;
  bba_pkg::flags_t       pf, pf_next;
  bba_pkg::status_t      st, st_next;
  logic [31:0]           ga, ga_next;
  logic [NW-1:0]         clr_cnt;

  // node flag memory
  bba_pkg::flags_t mem [bba_pkg::NODE_COUNT];
  bba_pkg::flags_t rd0, rd1;
  logic            we;
  logic [NW-1:0]   wa, ra0, ra1;
  bba_pkg::flags_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // tree navigation
  logic [NW-1:0] left_n, right_n, parent_n, level_base, pos;
  logic [DW-1:0] td;
  logic [31:0]   off;

  assign left_n     = {node[NW-2:0], 1'b1};
  assign right_n    = left_n + NW'(1);
  assign parent_n   = (node - NW'(1)) >> 1;
  assign td         = DW'(LW'(bba_pkg::HEAP_LOG2) - k);
  assign level_base = (NW'(1) << td) - NW'(1);
  assign pos        = fnode - level_base;
  assign off        = addr_r - heap_base;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && !out_valid;

  // sequencer
  always_comb begin
    state_next = state;
    k_next     = k;
    node_next  = node;
    fnode_next = fnode;
    dep_next   = dep;
    pf_next    = pf;
    st_next    = st;
    ga_next    = ga;
    we         = 1'b0;
    wa         = node;
    wd         = bba_pkg::FLAGS_CLEAR;
    ra0        = node;
    ra1        = node;
    case (state)
      ST_CLR: begin
        we = 1'b1;
        wa = clr_cnt;
        if (clr_cnt == NW'(bba_pkg::NODE_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_ready) state_next = ST_KCALC;
      end
      ST_KCALC: begin
        k_next     = bba_pkg::round_log2(size_r);
        st_next    = bba_pkg::STATUS_OK;
        ga_next    = '0;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        if (k > LW'(bba_pkg::HEAP_LOG2)) begin
          st_next    = bba_pkg::STATUS_TOO_LARGE;
          state_next = ST_FIN;
        end else if (mode_r == bba_pkg::MODE_ALLOC) begin
          node_next  = '0;
          dep_next   = '0;
          state_next = ST_S_RD;
        end else if (off[31:bba_pkg::HEAP_LOG2] != '0) begin
          st_next    = bba_pkg::STATUS_NO_BLOCK;
          state_next = ST_FIN;
        end else begin
          node_next  = level_base + NW'(off[bba_pkg::HEAP_LOG2-1:0] >> k);
          state_next = ST_F_RD;
        end
      end
      // depth-first search, left before right
      ST_S_RD: state_next = ST_S_EV;
      ST_S_EV: begin
        if (rd0[bba_pkg::FLAG_FULL]) begin
          state_next = ST_S_BACK;
        end else if (dep >= td) begin
          state_next = rd0[bba_pkg::FLAG_SPLIT] ? ST_S_BACK : ST_FOUND;
        end else if (!rd0[bba_pkg::FLAG_SPLIT]) begin
          state_next = ST_S_WSPL;
        end else begin
          node_next  = left_n;
          dep_next   = dep + DW'(1);
          state_next = ST_S_RD;
        end
      end
      ST_S_BACK: begin
        if (node == '0) begin
          st_next    = bba_pkg::STATUS_NO_BLOCK;
          state_next = ST_FIN;
        end else if (node[0]) begin
          node_next  = node + NW'(1);
          state_next = ST_S_RD;
        end else begin
          node_next = parent_n;
          dep_next  = dep - DW'(1);
        end
      end
      ST_S_WSPL: begin
        we         = 1'b1;
        wd         = bba_pkg::FLAGS_SPLIT;
        state_next = ST_S_WL;
      end
      ST_S_WL: begin
        we         = 1'b1;
        wa         = left_n;
        state_next = ST_S_WR;
      end
      ST_S_WR: begin
        we         = 1'b1;
        wa         = right_n;
        node_next  = left_n;
        dep_next   = dep + DW'(1);
        state_next = ST_S_RD;
      end
      ST_FOUND: begin
        we         = 1'b1;
        wd         = bba_pkg::FLAGS_FULL;
        fnode_next = node;
        if (node == '0) begin
          state_next = ST_ADDR;
        end else begin
          node_next  = parent_n;
          state_next = ST_A_RD;
        end
      end
      // ancestors become full while both children are full
      ST_A_RD: begin
        ra0        = left_n;
        ra1        = right_n;
        state_next = ST_A_EV;
      end
      ST_A_EV: begin
        if (rd0[bba_pkg::FLAG_FULL] && rd1[bba_pkg::FLAG_FULL]) begin
          we = 1'b1;
          wd = bba_pkg::FLAGS_BOTH;
          if (node == '0) begin
            state_next = ST_ADDR;
          end else begin
            node_next  = parent_n;
            state_next = ST_A_RD;
          end
        end else begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        ga_next    = heap_base + (32'(pos) << k);
        state_next = ST_FIN;
      end
      // free and merge upward
      ST_F_RD: state_next = ST_F_EV;
      ST_F_EV: begin
        we = 1'b1;
        wd = rd0 & ~bba_pkg::FLAGS_FULL;
        if (node == '0) begin
          state_next = ST_FIN;
        end else begin
          node_next  = parent_n;
          state_next = ST_P_RD;
        end
      end
      ST_P_RD: state_next = ST_P_EV;
      ST_P_EV: begin
        pf_next    = rd0;
        state_next = (rd0 == bba_pkg::FLAGS_CLEAR) ? ST_FIN : ST_C_RD;
      end
      ST_C_RD: begin
        ra0        = left_n;
        ra1        = right_n;
        state_next = ST_C_EV;
      end
      ST_C_EV: begin
        we = 1'b1;
        if ((rd0 | rd1) != bba_pkg::FLAGS_CLEAR) begin
          if (rd0[bba_pkg::FLAG_FULL] && rd1[bba_pkg::FLAG_FULL]) wd = pf | bba_pkg::FLAGS_FULL;
          else wd = pf & ~bba_pkg::FLAGS_FULL;
          state_next = ST_FIN;
        end else if (node == '0) begin
          state_next = ST_FIN;
        end else begin
          node_next  = parent_n;
          state_next = ST_P_RD;
        end
      end
      ST_FIN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      heap_base <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) clr_cnt <= clr_cnt + NW'(1);
      if (cfg_valid && cfg_ready) heap_base <= cfg_data;
      if (state == ST_FIN) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= mode;
      size_r <= request_size;
      addr_r <= block_address;
    end
    k     <= k_next;
    node  <= node_next;
    fnode <= fnode_next;
    dep   <= dep_next;
    pf    <= pf_next;
    st    <= st_next;
    ga    <= ga_next;
    if (state == ST_FIN) begin
      status            <= st;
      granted_address   <= ga;
      granted_size_log2 <= (st == bba_pkg::STATUS_TOO_LARGE) ? '0 : k;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_only_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_IDLE) else $error("result pending outside idle");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !in_ready) else $error("request taken during clear");
  a_too_large_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bba_pkg::STATUS_TOO_LARGE |->
      granted_address == '0 && granted_size_log2 == '0) else $error("oversize result");
  a_fin_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |=> state == ST_IDLE && out_valid) else $error("result not posted");
`endif

endmodule

@@ verif/buddy_block_allocator_core_test.sv @@
`timescale 1ns / 1ps
module buddy_block_allocator_core_test;

  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    bba_pkg::status_t st;
    logic [31:0]      addr;
    logic [4:0]       size_log2;
  } grant_t;

  typedef struct {
    logic [31:0] addr;
    int          size_log2;
  } live_block_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = bba_pkg::MODE_ALLOC;
  logic [20:0] request_size = '0;
  logic [31:0] block_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] granted_address;
  logic [4:0]  granted_size_log2;

  // predictor state
  bba_pkg::flags_t tree [bba_pkg::NODE_COUNT];
  logic [31:0]     base_addr = '0;
  grant_t          pending_grants [$];
  live_block_t     live_blocks [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  buddy_block_allocator_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .request_size(request_size), .block_address(block_address),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .granted_address(granted_address), .granted_size_log2(granted_size_log2)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h log2=%0d", $time, status,
                 granted_address, granted_size_log2);
        errors++;
      end else begin
        g = pending_grants.pop_front();
        if (status !== g.st) begin
          $display("%0t: status expected %0d actual %0d", $time, g.st, status);
          errors++;
        end
        if (granted_address !== g.addr) begin
          $display("%0t: granted_address expected %h actual %h", $time, g.addr,
                   granted_address);
          errors++;
        end
        if (granted_size_log2 !== g.size_log2) begin
          $display("%0t: granted_size_log2 expected %0d actual %0d", $time, g.size_log2,
                   granted_size_log2);
          errors++;
        end
      end
    end
  end

  function automatic int size_to_log2(logic [20:0] size);
    int k;
    k = bba_pkg::MIN_BLOCK_LOG2;
    while (k < 31 && (64'd1 << k) < size) k++;
    return k;
  endfunction

  // depth-first search, left before right, splitting on the way down
  function automatic bit find_block(int k, output int found);
    int stk_node [bba_pkg::DEPTH_MAX + 2];
    int stk_lvl [bba_pkg::DEPTH_MAX + 2];
    int stk_stage [bba_pkg::DEPTH_MAX + 2];
    int sp, n, lg;
    bit ok;
    sp = 1; stk_node[0] = 0; stk_lvl[0] = bba_pkg::HEAP_LOG2; stk_stage[0] = 0;
    ok = 0; found = 0;
    while (sp > 0 && !ok) begin
      n = stk_node[sp-1];
      lg = stk_lvl[sp-1];
      case (stk_stage[sp-1])
        0: begin
          if (tree[n][bba_pkg::FLAG_FULL]) sp--;
          else if (lg <= k) begin
            if (tree[n][bba_pkg::FLAG_SPLIT]) sp--;
            else begin
              tree[n][bba_pkg::FLAG_FULL] = 1'b1;
              found = n;
              ok = 1;
            end
          end else begin
            if (!tree[n][bba_pkg::FLAG_SPLIT]) begin
              tree[n][bba_pkg::FLAG_SPLIT] = 1'b1;
              tree[2*n+1] = bba_pkg::FLAGS_CLEAR;
              tree[2*n+2] = bba_pkg::FLAGS_CLEAR;
            end
            stk_stage[sp-1] = 1;
          end
        end
        1, 2: begin
          int c;
          c = 2*n + stk_stage[sp-1];
          stk_stage[sp-1]++;
          if (!tree[c][bba_pkg::FLAG_FULL]) begin
            stk_node[sp] = c; stk_lvl[sp] = lg - 1; stk_stage[sp] = 0;
            sp++;
          end
        end
        default: sp--;
      endcase
    end
    return ok;
  endfunction

  // clear full and merge buddies upward
  function automatic void release_block(int n);
    int p;
    bba_pkg::flags_t lf, rf;
    tree[n][bba_pkg::FLAG_FULL] = 1'b0;
    if (n == 0) return;
    p = (n - 1) >> 1;
    while (tree[p] != bba_pkg::FLAGS_CLEAR) begin
      lf = tree[2*p+1];
      rf = tree[2*p+2];
      if ((lf | rf) != bba_pkg::FLAGS_CLEAR) begin
        tree[p][bba_pkg::FLAG_FULL] = lf[bba_pkg::FLAG_FULL] & rf[bba_pkg::FLAG_FULL];
        return;
      end
      tree[p] = bba_pkg::FLAGS_CLEAR;
      if (p == 0) return;
      p = (p - 1) >> 1;
    end
  endfunction

  function automatic grant_t predict_grant(logic m, logic [20:0] size, logic [31:0] addr);
    grant_t g;
    int k, found, n, d;
    logic [31:0] off;
    k = size_to_log2(size);
    g.st = bba_pkg::STATUS_OK; g.addr = '0; g.size_log2 = 5'(k);
    if (k > bba_pkg::HEAP_LOG2) begin
      g.st = bba_pkg::STATUS_TOO_LARGE;
      g.size_log2 = '0;
    end else if (m == bba_pkg::MODE_ALLOC) begin
      if (find_block(k, found)) begin
        d = bba_pkg::HEAP_LOG2 - k;
        n = found;
        while (n != 0) begin
          n = (n - 1) >> 1;
          if (tree[2*n+1][bba_pkg::FLAG_FULL] && tree[2*n+2][bba_pkg::FLAG_FULL])
            tree[n][bba_pkg::FLAG_FULL] = 1'b1;
        end
        g.addr = base_addr + (32'(found - ((1 << d) - 1)) << k);
      end else g.st = bba_pkg::STATUS_NO_BLOCK;
    end else begin
      off = addr - base_addr;
      if (off >= (32'd1 << bba_pkg::HEAP_LOG2)) g.st = bba_pkg::STATUS_NO_BLOCK;
      else release_block(((1 << (bba_pkg::HEAP_LOG2 - k)) - 1) + int'(off >> k));
    end
    return g;
  endfunction

  // one request transfer; valid stays high between back-to-back requests
  task automatic send_request(logic m, logic [20:0] size, logic [31:0] addr);
    grant_t g;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    request_size <= size;
    block_address <= addr;
    do @(posedge clk); while (!in_ready);
    g = predict_grant(m, size, addr);
    pending_grants.push_back(g);
    if (m == bba_pkg::MODE_ALLOC && g.st == bba_pkg::STATUS_OK)
      live_blocks.push_back('{g.addr, int'(g.size_log2)});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_heap_base(logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    base_addr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic free_everything();
    live_block_t b;
    while (live_blocks.size() != 0) begin
      b = live_blocks.pop_front();
      send_request(bba_pkg::MODE_FREE, 21'(1 << b.size_log2), b.addr);
    end
  endtask

  task automatic test_size_edges();
    send_request(bba_pkg::MODE_ALLOC, 21'd0, '0);
    send_request(bba_pkg::MODE_ALLOC, 21'd1, 32'hFFFF_FFFF);
    send_request(bba_pkg::MODE_ALLOC, 21'd1024, '0);
    send_request(bba_pkg::MODE_ALLOC, 21'd1025, '0);
    send_request(bba_pkg::MODE_ALLOC, 21'h10_0001, '0);
    send_request(bba_pkg::MODE_ALLOC, 21'h1F_FFFF, '0);
    send_request(bba_pkg::MODE_FREE, 21'h1F_FFFF, '0);
    free_everything();
    send_request(bba_pkg::MODE_ALLOC, 21'h10_0000, '0);
    free_everything();
  endtask

  task automatic test_exhaust();
    // two halves fill the heap, so any further allocation fails
    send_request(bba_pkg::MODE_ALLOC, 21'h8_0000, '0);
    send_request(bba_pkg::MODE_ALLOC, 21'h8_0000, '0);
    send_request(bba_pkg::MODE_ALLOC, 21'd1, '0);
    free_everything();
  endtask

  task automatic test_free_cases();
    send_request(bba_pkg::MODE_ALLOC, 21'd4096, '0);
    // free outside the heap
    send_request(bba_pkg::MODE_FREE, 21'd4096, base_addr + 32'h10_0000);
    send_request(bba_pkg::MODE_FREE, 21'd4096, base_addr - 32'd1);
    // misaligned free hits the containing block
    send_request(bba_pkg::MODE_FREE, 21'd4096, base_addr + 32'd123);
    // free of a split node and of an already free node
    send_request(bba_pkg::MODE_ALLOC, 21'd2048, '0);
    send_request(bba_pkg::MODE_FREE, 21'h10_0000, base_addr);
    send_request(bba_pkg::MODE_FREE, 21'd1024, base_addr + 32'h4_0000);
    live_blocks.delete();
    send_request(bba_pkg::MODE_FREE, 21'h10_0000, base_addr);
  endtask

  task automatic run_random(int count, int idle, int stall);
    int lg, pick, kind;
    logic [20:0] size;
    live_block_t b;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        // noise over the full field ranges
        send_request(1'($urandom), 21'($urandom), $urandom);
      end else if (live_blocks.size() == 0 || kind < 60) begin
        lg = ($urandom_range(5) == 0) ? $urandom_range(15, 20) : $urandom_range(10, 13);
        size = (lg == 10) ? 21'($urandom_range(1, 1024))
                          : 21'($urandom_range((1 << (lg - 1)) + 1, 1 << lg));
        send_request(bba_pkg::MODE_ALLOC, size, 32'($urandom));
      end else begin
        pick = $urandom_range(live_blocks.size() - 1);
        b = live_blocks[pick];
        live_blocks.delete(pick);
        send_request(bba_pkg::MODE_FREE, 21'(1 << b.size_log2),
                     b.addr + 32'($urandom_range((1 << b.size_log2) - 1)));
      end
      if (live_blocks.size() > 40) free_everything();
    end
    free_everything();
  endtask

  task automatic test_heap_base();
    set_heap_base(32'hFFFF_FFFF);
    run_random(150, 0, 0);
    set_heap_base(32'hFFF8_0000);
    run_random(150, 87, 0);
    // pause until every outstanding result is back
    wait_drained();
    set_heap_base('0);
    run_random(150, 0, 87);
    set_heap_base($urandom);
    run_random(150, 8, 8);
  endtask

  task automatic test_random_mix();
    run_random(300, 0, 0);
    set_heap_base($urandom);
    run_random(200, 87, 0);
    set_heap_base(32'h8000_0000);
    run_random(200, 0, 87);
    run_random(100, 8, 8);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < bba_pkg::NODE_COUNT; i++) tree[i] = bba_pkg::FLAGS_CLEAR;
    test_size_edges();
    test_exhaust();
    test_free_cases();
    test_heap_base();
    test_random_mix();
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
